FILE: hw/rtl/ebce_pkg.sv
// ebce_pkg: shared types and constants of the 8-bit cpu execute block
// opcodes, fault codes, branch conditions and the structs passed between modules
// no dependencies
`timescale 1ns / 1ps

package ebce_pkg;

   localparam int INS_W         = 16;
   localparam int PC_W          = 10;
   localparam int DATA_W        = 8;
   localparam int REG_AW        = 4;
   localparam int REG_COUNT     = 16;
   localparam int MEM_AW        = 8;
   localparam int PROGRAM_WORDS = 1024;

   typedef enum logic [3:0] {
      OP_NOP = 4'd0,
      OP_HLT = 4'd1,
      OP_ADD = 4'd2,
      OP_SUB = 4'd3,
      OP_NOR = 4'd4,
      OP_AND = 4'd5,
      OP_XOR = 4'd6,
      OP_RSH = 4'd7,
      OP_LDI = 4'd8,
      OP_ADI = 4'd9,
      OP_JMP = 4'd10,
      OP_BRH = 4'd11,
      OP_CAL = 4'd12,
      OP_RET = 4'd13,
      OP_LOD = 4'd14,
      OP_STR = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      COND_ZSET = 2'd0,
      COND_ZCLR = 2'd1,
      COND_CSET = 2'd2,
      COND_CCLR = 2'd3
   } cond_type;

   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

   // register file write request
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } rf_wr_type;

   // data memory write request
   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } dm_wr_type;

   // one response item
   typedef struct packed {
      logic [PC_W-1:0] next_pc;
      logic            halted;
      logic            zero_flag;
      logic            carry_flag;
      logic [1:0]      stack_fault;
   } rsp_type;

endpackage

FILE: hw/rtl/ebce_if.sv
// ebce_if: request and response channel interfaces of the cpu execute block
// valid/ready handshake with the payload fields; depends on ebce_pkg
`timescale 1ns / 1ps

interface ebce_req_if import ebce_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [INS_W-1:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface ebce_rsp_if import ebce_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PC_W-1:0] next_pc;
   logic            halted;
   logic            zero_flag;
   logic            carry_flag;
   logic [1:0]      stack_fault;

   modport source (output valid, output next_pc, output halted, output zero_flag,
                   output carry_flag, output stack_fault, input ready);
   modport sink   (input valid, input next_pc, input halted, input zero_flag,
                   input carry_flag, input stack_fault, output ready);
endinterface

FILE: hw/rtl/eight_bit_cpu_execute.sv
// eight_bit_cpu_execute: executes one 16-bit instruction per request
// a request passes the execute register, the write-back register and the response queue before its response is offered
// throughput: one instruction per cycle; the pipeline stalls only when the
//    two-entry response queue is full
// reset: synchronous; registers, flags, pc and stack depth clear at once, register
//    file and data memory read zero through valid bits, so no clearing pass is needed
`timescale 1ns / 1ps

module eight_bit_cpu_execute import ebce_pkg::*; #(
   parameter int STACK_ENTRIES = 16,
   parameter int DATA_BYTES    = 256
) (
   input  logic       clock,
   input  logic       reset,
   ebce_req_if.sink   req_if,
   ebce_rsp_if.source rsp_if
);

   localparam int DW = $clog2(STACK_ENTRIES + 1);
   localparam int SW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

   // pipeline control and architectural state
   logic             advance;
   logic             s1_valid_ff;
   logic [INS_W-1:0] s1_ins_ff;
   logic             s2_valid_ff;
   rsp_type          s2_rsp_ff;
   logic             s2_wr_en_ff;
   logic [REG_AW-1:0] s2_wr_addr_ff;
   logic [DATA_W-1:0] s2_alu_ff;
   logic             s2_load_ff;
   rf_wr_type        s3_wr_ff;
   logic [PC_W-1:0]  pc_ff;
   logic             zf_ff;
   logic             cf_ff;
   logic             stopped_ff;
   logic [DW-1:0]    depth_ff;

   // decode
   op_type           op;
   logic [REG_AW-1:0] ra;
   logic [REG_AW-1:0] rb;
   logic [REG_AW-1:0] rc;
   logic [7:0]       imm;
   logic [PC_W-1:0]  jaddr;
   cond_type         cond;
   logic             active;

   // operands and results
   logic [DATA_W-1:0] rf_a;
   logic [DATA_W-1:0] rf_b;
   logic [DATA_W-1:0] va;
   logic [DATA_W-1:0] vb;
   logic [DATA_W-1:0] s2_wdata;
   logic [DATA_W-1:0] dm_rd_data;
   logic [PC_W-1:0]  stk_rd_data;
   logic [8:0]       sum9;
   logic [PC_W:0]    seq;
   logic [MEM_AW-1:0] maddr;
   rf_wr_type        rf_wr;
   dm_wr_type        dm_wr;
   rsp_type          rsp_in;
   rsp_type          fifo_out;
   logic             fifo_space;

   // next values
   logic [PC_W:0]    target_in;
   logic             stop_in;
   logic [1:0]       fault_in;
   logic             zf_in;
   logic             cf_in;
   logic [DW-1:0]    depth_in;
   logic             wr_en_in;
   logic [REG_AW-1:0] wr_addr_in;
   logic [DATA_W-1:0] alu_in;
   logic             load_in;
   logic             push_en;
   logic             taken;

   assign advance       = fifo_space;
   assign req_if.ready  = advance;

   // field decode of the instruction in execute
   assign op     = op_type'(s1_ins_ff[15:12]);
   assign ra     = s1_ins_ff[11:8];
   assign rb     = s1_ins_ff[7:4];
   assign rc     = s1_ins_ff[3:0];
   assign imm    = s1_ins_ff[7:0];
   assign jaddr  = s1_ins_ff[PC_W-1:0];
   assign cond   = cond_type'(s1_ins_ff[11:10]);
   assign active = s1_valid_ff && !stopped_ff;

   // register file, read in the accept cycle
   ebce_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (advance),
      .rd_addr_a (req_if.instruction[11:8]),
      .rd_addr_b (req_if.instruction[7:4]),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr        (rf_wr)
   );

   // write-back stage: load data or alu result
   assign s2_wdata = s2_load_ff ? dm_rd_data : s2_alu_ff;
   assign rf_wr    = '{en:   advance && s2_valid_ff && s2_wr_en_ff,
                       addr: s2_wr_addr_ff,
                       data: s2_wdata};

   // operand forwarding from write-back and from the registered previous write
   always_comb begin
      if (s2_valid_ff && s2_wr_en_ff && (s2_wr_addr_ff == ra)) begin
         va = s2_wdata;
      end else if (s3_wr_ff.en && (s3_wr_ff.addr == ra)) begin
         va = s3_wr_ff.data;
      end else begin
         va = rf_a;
      end
      if (s2_valid_ff && s2_wr_en_ff && (s2_wr_addr_ff == rb)) begin
         vb = s2_wdata;
      end else if (s3_wr_ff.en && (s3_wr_ff.addr == rb)) begin
         vb = s3_wr_ff.data;
      end else begin
         vb = rf_b;
      end
   end

   assign seq   = {1'b0, pc_ff} + (PC_W+1)'(1);
   assign sum9  = {1'b0, va} + {1'b0, (op == OP_SUB) ? ~vb : vb} + 9'(cf_ff);
   assign maddr = va + {4'b0000, rc};

   // execute: flags, branch target, stack and write-back selection
   always_comb begin
      target_in  = seq;
      stop_in    = 1'b0;
      fault_in   = FAULT_NONE;
      zf_in      = zf_ff;
      cf_in      = cf_ff;
      depth_in   = depth_ff;
      wr_en_in   = 1'b0;
      wr_addr_in = rc;
      alu_in     = '0;
      load_in    = 1'b0;
      push_en    = 1'b0;
      taken      = 1'b0;
      if (active) begin
         case (op)
            OP_NOP: begin
            end
            OP_HLT: begin
               stop_in   = 1'b1;
               target_in = {1'b0, pc_ff};
            end
            OP_ADD, OP_SUB: begin
               alu_in   = sum9[7:0];
               wr_en_in = 1'b1;
               zf_in    = (sum9[7:0] == 8'd0);
               cf_in    = sum9[8];
            end
            OP_NOR: begin
               alu_in   = ~(va | vb);
               wr_en_in = 1'b1;
               zf_in    = (alu_in == 8'd0);
            end
            OP_AND: begin
               alu_in   = va & vb;
               wr_en_in = 1'b1;
               zf_in    = (alu_in == 8'd0);
            end
            OP_XOR: begin
               alu_in   = va ^ vb;
               wr_en_in = 1'b1;
               zf_in    = (alu_in == 8'd0);
            end
            OP_RSH: begin
               alu_in   = {1'b0, va[7:1]};
               wr_en_in = 1'b1;
            end
            OP_LDI: begin
               alu_in     = imm;
               wr_en_in   = 1'b1;
               wr_addr_in = ra;
            end
            OP_ADI: begin
               alu_in     = va + imm;
               wr_en_in   = 1'b1;
               wr_addr_in = ra;
               zf_in      = (alu_in == 8'd0);
            end
            OP_JMP: begin
               target_in = {1'b0, jaddr};
            end
            OP_BRH: begin
               case (cond)
                  COND_ZSET: taken = zf_ff;
                  COND_ZCLR: taken = !zf_ff;
                  COND_CSET: taken = cf_ff;
                  COND_CCLR: taken = !cf_ff;
                  default:   taken = 1'b0;
               endcase
               if (taken) begin
                  target_in = {1'b0, jaddr};
               end
            end
            OP_CAL: begin
               if (depth_ff == DW'(STACK_ENTRIES)) begin
                  fault_in  = FAULT_OVERFLOW;
                  stop_in   = 1'b1;
                  target_in = {1'b0, pc_ff};
               end else begin
                  push_en   = 1'b1;
                  depth_in  = depth_ff + DW'(1);
                  target_in = {1'b0, jaddr};
               end
            end
            OP_RET: begin
               if (depth_ff == '0) begin
                  fault_in  = FAULT_UNDERFLOW;
                  stop_in   = 1'b1;
                  target_in = {1'b0, pc_ff};
               end else begin
                  depth_in  = depth_ff - DW'(1);
                  target_in = {1'b0, stk_rd_data};
               end
            end
            OP_LOD: begin
               wr_en_in   = 1'b1;
               wr_addr_in = rb;
               load_in    = 1'b1;
            end
            OP_STR: begin
            end
            default: begin
            end
         endcase
         // running past the last program word stops the core in place
         if (target_in >= (PC_W+1)'(PROGRAM_WORDS)) begin
            stop_in   = 1'b1;
            target_in = {1'b0, pc_ff};
         end
      end
      // r0 is never written
      wr_en_in = wr_en_in && (wr_addr_in != '0);
   end

   // response of the instruction in execute
   always_comb begin
      rsp_in.next_pc     = active ? target_in[PC_W-1:0] : pc_ff;
      rsp_in.halted      = active ? stop_in : stopped_ff;
      rsp_in.zero_flag   = zf_in;
      rsp_in.carry_flag  = cf_in;
      rsp_in.stack_fault = fault_in;
   end

   // data memory: load read and store write both happen in execute
   assign dm_wr = '{en:   advance && active && (op == OP_STR),
                    addr: maddr,
                    data: vb};

   ebce_dmem #(
      .DATA_BYTES (DATA_BYTES)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_addr (maddr),
      .rd_data (dm_rd_data),
      .wr      (dm_wr)
   );

   // return stack: read the top as it stands after this edge
   ebce_stack #(
      .STACK_ENTRIES (STACK_ENTRIES)
   ) u_stack (
      .clock     (clock),
      .rd_en     (advance),
      .rd_addr   (SW'(depth_in - DW'(1))),
      .rd_data   (stk_rd_data),
      .push_en   (advance && push_en),
      .push_addr (SW'(depth_ff)),
      .push_data (seq[PC_W-1:0])
   );

   // control state and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_wr_ff.en <= 1'b0;
         pc_ff       <= '0;
         zf_ff       <= 1'b0;
         cf_ff       <= 1'b0;
         stopped_ff  <= 1'b0;
         depth_ff    <= '0;
      end else if (advance) begin
         s1_valid_ff   <= req_if.valid;
         s2_valid_ff   <= s1_valid_ff;
         s3_wr_ff.en   <= s2_valid_ff && s2_wr_en_ff;
         s3_wr_ff.addr <= s2_wr_addr_ff;
         s3_wr_ff.data <= s2_wdata;
         if (active) begin
            pc_ff      <= target_in[PC_W-1:0];
            zf_ff      <= zf_in;
            cf_ff      <= cf_in;
            stopped_ff <= stop_in;
            depth_ff   <= depth_in;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ins_ff      <= req_if.instruction;
         s2_rsp_ff      <= rsp_in;
         s2_wr_en_ff    <= wr_en_in;
         s2_wr_addr_ff  <= wr_addr_in;
         s2_alu_ff      <= alu_in;
         s2_load_ff     <= load_in;
      end
   end

   // response queue
   ebce_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && s2_valid_ff),
      .push_data (s2_rsp_ff),
      .space     (fifo_space),
      .out_valid (rsp_if.valid),
      .out_data  (fifo_out),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.next_pc     = fifo_out.next_pc;
   assign rsp_if.halted      = fifo_out.halted;
   assign rsp_if.zero_flag   = fifo_out.zero_flag;
   assign rsp_if.carry_flag  = fifo_out.carry_flag;
   assign rsp_if.stack_fault = fifo_out.stack_fault;

endmodule

FILE: hw/rtl/ebce_regfile.sv
// ebce_regfile: 16 x 8 register file, two synchronous read ports, one write port
// per-entry valid bits make the whole file read zero after reset; depends on ebce_pkg
`timescale 1ns / 1ps

module ebce_regfile import ebce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_addr_a,
   input  logic [REG_AW-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b,
   input  rf_wr_type         wr
);

   logic [DATA_W-1:0]    mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [DATA_W-1:0]    a_ff;
   logic [DATA_W-1:0]    b_ff;
   logic                 a_ok_ff;
   logic                 b_ok_ff;

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // storage and registered reads (old data on a same-edge write)
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         a_ff    <= mem[rd_addr_a];
         b_ff    <= mem[rd_addr_b];
         a_ok_ff <= valid_ff[rd_addr_a];
         b_ok_ff <= valid_ff[rd_addr_b];
      end
   end

   // entries never written read as zero
   assign rd_data_a = a_ok_ff ? a_ff : '0;
   assign rd_data_b = b_ok_ff ? b_ff : '0;

endmodule

FILE: hw/rtl/ebce_dmem.sv
// ebce_dmem: byte-wide data memory with one synchronous read and one write port
// per-byte valid bits give the all-zero reset contents; depends on ebce_pkg
`timescale 1ns / 1ps

module ebce_dmem import ebce_pkg::*; #(
   parameter int DATA_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [MEM_AW-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  dm_wr_type         wr
);

   localparam int IW = $clog2(DATA_BYTES);

   logic [DATA_W-1:0]     mem [DATA_BYTES];
   logic [DATA_BYTES-1:0] valid_ff;
   logic [DATA_W-1:0]     rd_ff;
   logic                  rd_ok_ff;
   logic                  rd_in_range;
   logic                  wr_in_range;

   // addresses past the end load zero and drop stores
   assign rd_in_range = ({1'b0, rd_addr} < (MEM_AW+1)'(DATA_BYTES));
   assign wr_in_range = ({1'b0, wr.addr} < (MEM_AW+1)'(DATA_BYTES));

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr_in_range) begin
         valid_ff[wr.addr[IW-1:0]] <= 1'b1;
      end
   end

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr.addr[IW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         if (rd_in_range) begin
            rd_ff    <= mem[rd_addr[IW-1:0]];
            rd_ok_ff <= valid_ff[rd_addr[IW-1:0]];
         end else begin
            rd_ff    <= '0;
            rd_ok_ff <= 1'b0;
         end
      end
   end

   assign rd_data = rd_ok_ff ? rd_ff : '0;

endmodule

FILE: hw/rtl/ebce_stack.sv
// ebce_stack: return address stack memory, one write and one synchronous read port
// a write to the address being read is forwarded to the read register; depends on ebce_pkg
`timescale 1ns / 1ps

module ebce_stack import ebce_pkg::*; #(
   parameter  int STACK_ENTRIES = 16,
   localparam int SW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [SW-1:0]            rd_addr,
   output logic [PC_W-1:0]          rd_data,
   input  logic                     push_en,
   input  logic [SW-1:0]            push_addr,
   input  logic [PC_W-1:0]          push_data
);

   logic [PC_W-1:0] mem [STACK_ENTRIES];
   logic [PC_W-1:0] rd_ff;

   // write port and write-first read
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[push_addr] <= push_data;
      end
      if (rd_en) begin
         if (push_en && (push_addr == rd_addr)) begin
            rd_ff <= push_data;
         end else begin
            rd_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

FILE: hw/rtl/ebce_rsp_fifo.sv
// ebce_rsp_fifo: two-entry response queue between the pipeline and the response port
// lets the pipeline keep taking requests while a response waits; depends on ebce_pkg
`timescale 1ns / 1ps

module ebce_rsp_fifo import ebce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   rsp_type    ent_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = ent_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/ebce_checker.sv
// ebce_checker: port-level checks of the cpu execute block over time
// bound to eight_bit_cpu_execute; depends on ebce_pkg
`timescale 1ns / 1ps

module ebce_checker import ebce_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [PC_W-1:0] rsp_next_pc,
   input logic            rsp_halted,
   input logic [1:0]      rsp_stack_fault
);

   // no response is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered right after reset");

   // fault code is one of the defined codes
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_stack_fault == FAULT_NONE || rsp_stack_fault == FAULT_OVERFLOW ||
                     rsp_stack_fault == FAULT_UNDERFLOW))
      else $error("undefined stack fault code");

   // a stack fault always stops the core
   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_stack_fault != FAULT_NONE) |-> rsp_halted)
      else $error("stack fault without halt");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc) && $stable(rsp_halted))
      else $error("stalled response changed");

   // once halted, the following response stays halted and reports no fault
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_halted) ##1 rsp_valid
         |-> rsp_halted && (rsp_stack_fault == FAULT_NONE))
      else $error("core left the halted state");

endmodule

bind eight_bit_cpu_execute ebce_checker u_ebce_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_next_pc     (rsp_if.next_pc),
   .rsp_halted      (rsp_if.halted),
   .rsp_stack_fault (rsp_if.stack_fault)
);
